[hdl/clvag_pkg.sv]
// shared types, constants and widths of the chunk level voice activity gate
// no dependencies; imported by every module of the block
`default_nettype none

package clvag_pkg;

  localparam int CHUNK_SAMPLES = 1600;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 15;
  localparam int EVENT_W  = 3;
  localparam int CHUNKS_W = 16;
  localparam int QUIET_W  = 11;

  localparam int THR_W  = 15;
  localparam int SIL_W  = 10;
  localparam int MAX_W  = 16;
  localparam int MIN_W  = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = LEVEL_W + EVENT_W + CHUNKS_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // sample position and level sum
  localparam int CNT_W = $clog2(CHUNK_SAMPLES);
  localparam int SUM_W = $clog2(CHUNK_SAMPLES * 32768 + 1);

  // exact reciprocal: floor(x / N) = (x * M) >> S for every x below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(CHUNK_SAMPLES);
  localparam logic [63:0] DIV_MULT =
    ((64'd1 << DIV_SHIFT) + 64'(CHUNK_SAMPLES) - 64'd1) / 64'(CHUNK_SAMPLES);
  localparam int MULT_W = $clog2(DIV_MULT + 64'd1);
  localparam logic [MULT_W-1:0] MULT_K = DIV_MULT[MULT_W-1:0];
  localparam int PROD_W = SUM_W + MULT_W;
  localparam int QUOT_W = LEVEL_W + 1;

  // running sample total of an utterance
  localparam int TOTAL_W = $clog2(65535 * CHUNK_SAMPLES + 1);
  localparam int CMP_W   = (TOTAL_W > MIN_W) ? TOTAL_W : MIN_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);
  localparam logic [SIL_W-1:0] SIL_RESET = SIL_W'(10);
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(50);
  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(8000);

  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_CHUNKS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNKS      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SAMPLES     = 2'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_IDLE   = 3'd0,
    EV_START  = 3'd1,
    EV_CONT   = 3'd2,
    EV_ACCEPT = 3'd3,
    EV_SHORT  = 3'd4
  } event_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RECORD = 1'b1
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0] level_threshold;
    logic [SIL_W-1:0] silence_chunks;
    logic [MAX_W-1:0] max_chunks;
    logic [MIN_W-1:0] min_samples;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/clvag_accum.sv]
// absolute value accumulator over one chunk of samples
// depends on clvag_pkg
`default_nettype none

module clvag_accum
  import clvag_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     sum_valid,
  input  wire logic                sum_ready,
  output logic [SUM_W-1:0]         chunk_sum
);

  logic [SUM_W-1:0]    level_sum;
  logic [CNT_W-1:0]    sample_in_chunk;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    sum_next;
  logic                take;
  logic                last;

  // full-scale negative gives 0x8000, which is 32768 unsigned
  assign mag      = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
  assign sum_next = level_sum + SUM_W'(mag);
  assign in_ready = !sum_valid || sum_ready;
  assign take     = in_valid && in_ready;
  assign last     = (sample_in_chunk == CNT_W'(CHUNK_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum       <= '0;
      sample_in_chunk <= '0;
      sum_valid       <= 1'b0;
    end else begin
      if (sum_valid && sum_ready) begin
        sum_valid <= 1'b0;
      end
      if (take) begin
        if (last) begin
          level_sum       <= '0;
          sample_in_chunk <= '0;
          sum_valid       <= 1'b1;
        end else begin
          level_sum       <= sum_next;
          sample_in_chunk <= sample_in_chunk + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      chunk_sum <= sum_next;
    end
  end

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_ready |=> sum_valid && $stable(chunk_sum))
    else $error("chunk sum changed while stalled");

endmodule

`default_nettype wire

[hdl/clvag_divide.sv]
// chunk mean by reciprocal multiplication, one registered product
// depends on clvag_pkg
`default_nettype none

module clvag_divide
  import clvag_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sum_valid,
  output logic                  sum_ready,
  input  wire logic [SUM_W-1:0] chunk_sum,
  output logic                  prod_valid,
  input  wire logic             prod_ready,
  output logic [PROD_W-1:0]     product
);

  logic take;

  assign sum_ready = !prod_valid || prod_ready;
  assign take      = sum_valid && sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (take) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      product <= PROD_W'(chunk_sum) * PROD_W'(MULT_K);
    end
  end

endmodule

`default_nettype wire

[hdl/clvag_gate.sv]
// utterance state machine and result register
// depends on clvag_pkg
`default_nettype none

module clvag_gate
  import clvag_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              prod_valid,
  output logic                   prod_ready,
  input  wire logic [PROD_W-1:0] product,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [LEVEL_W-1:0]     level_out,
  output event_t                 event_out,
  output logic [CHUNKS_W-1:0]    chunks_out
);

  state_t              state;
  state_t              state_next;
  logic [CHUNKS_W-1:0] chunk_count;
  logic [CHUNKS_W-1:0] chunk_count_next;
  logic [QUIET_W-1:0]  quiet_count;
  logic [QUIET_W-1:0]  quiet_count_next;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_next;

  logic [QUOT_W-1:0]   quot;
  logic [LEVEL_W-1:0]  level;
  logic                loud;
  logic [CHUNKS_W-1:0] chunks_inc;
  logic [TOTAL_W-1:0]  total_inc;
  logic [QUIET_W-1:0]  quiet_new;
  logic                done;
  event_t              ev;
  logic [CHUNKS_W-1:0] count_res;
  logic                fire;

  assign quot       = product[DIV_SHIFT +: QUOT_W];
  assign level      = quot[QUOT_W-1] ? '1 : quot[LEVEL_W-1:0];
  assign loud       = level > cfg.level_threshold;
  assign prod_ready = !out_valid || out_ready;
  assign fire       = prod_valid && prod_ready;

  // counters hold at their maxima
  assign chunks_inc = (chunk_count == '1) ? chunk_count : chunk_count + CHUNKS_W'(1);
  assign total_inc  = (chunk_count == '1) ? total : total + TOTAL_W'(CHUNK_SAMPLES);
  assign quiet_new  = loud ? '0 :
                      ((quiet_count == '1) ? quiet_count : quiet_count + QUIET_W'(1));

  always_comb begin
    state_next       = state;
    chunk_count_next = chunk_count;
    quiet_count_next = quiet_count;
    total_next       = total;
    done             = 1'b0;
    ev               = EV_IDLE;
    count_res        = '0;
    unique case (state)
      ST_IDLE: begin
        if (loud) begin
          done      = (cfg.max_chunks <= MAX_W'(1));
          count_res = CHUNKS_W'(1);
          if (done) begin
            ev = (CMP_W'(CHUNK_SAMPLES) > CMP_W'(cfg.min_samples)) ? EV_ACCEPT : EV_SHORT;
          end else begin
            ev               = EV_START;
            state_next       = ST_RECORD;
            chunk_count_next = CHUNKS_W'(1);
            quiet_count_next = '0;
            total_next       = TOTAL_W'(CHUNK_SAMPLES);
          end
        end
      end
      ST_RECORD: begin
        done = (!loud && (quiet_new > QUIET_W'(cfg.silence_chunks))) ||
               (chunks_inc >= cfg.max_chunks);
        count_res = chunks_inc;
        if (done) begin
          ev = (CMP_W'(total_inc) > CMP_W'(cfg.min_samples)) ? EV_ACCEPT : EV_SHORT;
          state_next       = ST_IDLE;
          chunk_count_next = '0;
          quiet_count_next = '0;
          total_next       = '0;
        end else begin
          ev               = EV_CONT;
          chunk_count_next = chunks_inc;
          quiet_count_next = quiet_new;
          total_next       = total_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chunk_count <= '0;
      quiet_count <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        state       <= state_next;
        chunk_count <= chunk_count_next;
        quiet_count <= quiet_count_next;
        total       <= total_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      level_out  <= level;
      event_out  <= ev;
      chunks_out <= count_res;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> chunk_count == '0 && quiet_count == '0 && total == '0)
    else $error("counters left set while idle");

  a_total_track: assert property (@(posedge clk) disable iff (rst)
    total == TOTAL_W'(TOTAL_W'(chunk_count) * TOTAL_W'(CHUNK_SAMPLES)))
    else $error("sample total out of step with chunk count");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_out == EV_IDLE |-> chunks_out == '0)
    else $error("quiet idle result with nonzero chunk count");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    fire && (ev == EV_ACCEPT || ev == EV_SHORT) |=> state == ST_IDLE)
    else $error("utterance end did not return to idle");

endmodule

`default_nettype wire

[hdl/chunk_level_voice_activity_gate.sv]
// a result reaches the output register after its chunk's sum and reciprocal product are registered in turn
// throughput: one sample per cycle while the output is not back-pressured; one result per CHUNK_SAMPLES samples
// the three stages (accumulate, reciprocal multiply, decide) stall only on output back-pressure
// rst is synchronous: counters and state go idle, configuration registers take their defaults
// top level: configuration registers, stage wiring, stream packing; depends on clvag_pkg
`default_nettype none

module chunk_level_voice_activity_gate
  import clvag_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // chunk_level, event_res, utterance_chunks
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                cfg;
  logic                sum_valid;
  logic                sum_ready;
  logic [SUM_W-1:0]    chunk_sum;
  logic                prod_valid;
  logic                prod_ready;
  logic [PROD_W-1:0]   product;
  logic [LEVEL_W-1:0]  level_out;
  event_t              event_out;
  logic [CHUNKS_W-1:0] chunks_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold <= THR_RESET;
      cfg.silence_chunks  <= SIL_RESET;
      cfg.max_chunks      <= MAX_RESET;
      cfg.min_samples     <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_THRESHOLD: cfg.level_threshold <= cfg_data[THR_W-1:0];
        REG_SILENCE_CHUNKS:  cfg.silence_chunks  <= cfg_data[SIL_W-1:0];
        REG_MAX_CHUNKS:      cfg.max_chunks      <= cfg_data[MAX_W-1:0];
        REG_MIN_SAMPLES:     cfg.min_samples     <= cfg_data[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clvag_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[SAMPLE_W-1:0]),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .chunk_sum (chunk_sum)
  );

  clvag_divide u_divide (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .chunk_sum  (chunk_sum),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .product    (product)
  );

  clvag_gate u_gate (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .product    (product),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .level_out  (level_out),
    .event_out  (event_out),
    .chunks_out (chunks_out)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, chunks_out,
                    EVENT_W'(event_out), level_out};

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking bench for chunk_level_voice_activity_gate: per-chunk level and utterance events
// predicts each chunk result in a scoreboard class and compares field by field on the output stream
// depends on clvag_pkg and the gate rtl only

module tb_top;
  import clvag_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int HOLD_CYCLES  = 8000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_CHUNKS = 12;

  typedef enum int {TR_SLOW_SINK, TR_SLOW_SOURCE, TR_FULL_RATE} traffic_t;

  typedef struct {
    logic [LEVEL_W-1:0]  level;
    event_t              ev;
    logic [CHUNKS_W-1:0] chunks;
  } chunk_result_t;

  class chunk_event_predictor;
    logic [THR_W-1:0]    level_threshold;
    logic [SIL_W-1:0]    silence_chunks;
    logic [MAX_W-1:0]    max_chunks;
    logic [MIN_W-1:0]    min_samples;
    logic [25:0]         level_sum;
    int unsigned         chunk_pos;
    state_t              rec_state;
    logic [CHUNKS_W-1:0] chunk_count;
    logic [QUIET_W-1:0]  quiet_count;
    chunk_result_t       expected_events[$];
    int                  errors;

    function new();
      level_threshold = THR_RESET;
      silence_chunks  = SIL_RESET;
      max_chunks      = MAX_RESET;
      min_samples     = MIN_RESET;
      level_sum       = '0;
      chunk_pos       = 0;
      rec_state       = ST_IDLE;
      chunk_count     = '0;
      quiet_count     = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LEVEL_THRESHOLD: level_threshold = data[THR_W-1:0];
        REG_SILENCE_CHUNKS:  silence_chunks  = data[SIL_W-1:0];
        REG_MAX_CHUNKS:      max_chunks      = data[MAX_W-1:0];
        REG_MIN_SAMPLES:     min_samples     = data[MIN_W-1:0];
        default: ;
      endcase
    endfunction

    function event_t close_utterance();
      longint unsigned total;
      total = chunk_count;
      total = total * CHUNK_SAMPLES;
      rec_state = ST_IDLE;
      return (total > min_samples) ? EV_ACCEPT : EV_SHORT;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      logic [16:0]   mag;
      int unsigned   level;
      bit            loud;
      bit            done;
      chunk_result_t r;
      mag = raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      level_sum += mag;
      chunk_pos++;
      if (chunk_pos < CHUNK_SAMPLES) return;
      level = level_sum / CHUNK_SAMPLES;
      if (level > 32767) level = 32767;
      level_sum = '0;
      chunk_pos = 0;
      loud = level > level_threshold;
      r.level = level[LEVEL_W-1:0];
      if (rec_state == ST_IDLE) begin
        if (loud) begin
          rec_state   = ST_RECORD;
          chunk_count = 1;
          quiet_count = '0;
          r.ev = EV_START;
          if (chunk_count >= max_chunks) r.ev = close_utterance();
          r.chunks = chunk_count;
        end else begin
          r.ev = EV_IDLE;
          r.chunks = '0;
        end
      end else begin
        done = 1'b0;
        if (chunk_count != '1) chunk_count++;
        if (loud) begin
          quiet_count = '0;
        end else begin
          if (quiet_count != '1) quiet_count++;
          done = quiet_count > silence_chunks;
        end
        if (chunk_count >= max_chunks) done = 1'b1;
        r.ev = done ? close_utterance() : EV_CONT;
        r.chunks = chunk_count;
      end
      if (rec_state == ST_IDLE) begin
        chunk_count = '0;
        quiet_count = '0;
      end
      expected_events.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] t);
      chunk_result_t       want;
      logic [LEVEL_W-1:0]  lvl;
      logic [EVENT_W-1:0]  ev;
      logic [CHUNKS_W-1:0] cnt;
      lvl = t[LEVEL_W-1:0];
      ev  = t[LEVEL_W +: EVENT_W];
      cnt = t[LEVEL_W+EVENT_W +: CHUNKS_W];
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: level %0d event %0d chunks %0d", lvl, ev, cnt);
        return;
      end
      want = expected_events.pop_front();
      if (lvl !== want.level || ev !== want.ev || cnt !== want.chunks) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: level exp %0d got %0d, event exp %0d got %0d, chunks exp %0d got %0d",
                   want.level, lvl, want.ev, ev, want.chunks, cnt);
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // chunk_level, event_res, utterance_chunks
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  chunk_event_predictor predictor;
  traffic_t             traffic;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  int                   cycle_count = 0;

  chunk_level_voice_activity_gate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int source_idle_pct();
    case (traffic)
      TR_SLOW_SINK:   return 9;
      TR_SLOW_SOURCE: return 69;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_idle_pct();
    case (traffic)
      TR_SLOW_SINK:   return 69;
      TR_SLOW_SOURCE: return 9;
      default:        return 0;
    endcase
  endfunction

  // output side: check accepted results, then choose next ready; one long hold at full rate
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) predictor.check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (traffic == TR_FULL_RATE && !hold_done && s_tvalid) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic offer_sample(input logic [SAMPLE_W-1:0] raw);
    while ($urandom_range(0, 99) < source_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predictor.note_sample(raw);
  endtask

  // magnitudes drawn from lo..hi with random sign, or raw noise over the full range
  task automatic send_chunk(input int lo, input int hi, input bit noise);
    logic [SAMPLE_W-1:0] raw;
    int                  m;
    for (int i = 0; i < CHUNK_SAMPLES; i++) begin
      if (noise) begin
        raw = SAMPLE_W'($urandom);
      end else begin
        m = $urandom_range(hi, lo);
        if (m == 32768 || (m != 0 && $urandom_range(0, 1) == 1)) raw = SAMPLE_W'(-m);
        else raw = SAMPLE_W'(m);
      end
      offer_sample(raw);
    end
  endtask

  task automatic exact_chunk(input int m);
    send_chunk(m, m, 1'b0);
  endtask

  task automatic loud_chunk();
    int thr;
    int hi;
    thr = predictor.level_threshold;
    hi  = thr + 1 + $urandom_range(0, 2000);
    if (hi > 32768) hi = 32768;
    send_chunk(thr + 1, hi, 1'b0);
  endtask

  task automatic quiet_chunk();
    int thr;
    int lo;
    thr = predictor.level_threshold;
    lo  = thr - $urandom_range(0, 2000);
    if (lo < 0) lo = 0;
    send_chunk(lo, thr, 1'b0);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    predictor.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] sil,
                            input logic [CFG_DATA_W-1:0] mx, input logic [CFG_DATA_W-1:0] mn);
    wait_drain();
    write_reg(REG_LEVEL_THRESHOLD, thr);
    write_reg(REG_SILENCE_CHUNKS, sil);
    write_reg(REG_MAX_CHUNKS, mx);
    write_reg(REG_MIN_SAMPLES, mn);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] sil;
    logic [CFG_DATA_W-1:0] mx;
    logic [CFG_DATA_W-1:0] mn;
    int                    pick;
    predictor = new();
    traffic   = TR_SLOW_SINK;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values: level at threshold is quiet, one above starts; ends on silence
    exact_chunk(500);
    exact_chunk(501);
    repeat (2) loud_chunk();
    repeat (11) quiet_chunk();

    // zero threshold, no silence allowed, widest limits
    set_config(24'd0, 24'd0, 24'd65535, 24'hFFFFFF);
    exact_chunk(0);
    exact_chunk(1);
    exact_chunk(0);
    exact_chunk(32768);
    send_chunk(0, 0, 1'b1);
    exact_chunk(0);

    // top threshold: full-scale negative saturates and stays quiet
    set_config(24'd32767, 24'd1023, 24'd1, 24'd0);
    exact_chunk(32768);
    exact_chunk(32767);

    // start at the limit
    set_config(24'd1000, 24'd2, 24'd1, 24'd0);
    repeat (2) loud_chunk();
    set_config(24'd1000, 24'd5, 24'd0, 24'd1600);
    loud_chunk();

    // ends on chunk limit
    set_config(24'd100, 24'd5, 24'd3, 24'd3200);
    loud_chunk();
    quiet_chunk();
    loud_chunk();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 2) traffic = TR_SLOW_SINK;
      else if (p < 5) traffic = TR_SLOW_SOURCE;
      else traffic = TR_FULL_RATE;
      if ($urandom_range(0, 99) < 10) thr = CFG_DATA_W'($urandom_range(0, 32767));
      else thr = CFG_DATA_W'($urandom_range(50, 12000));
      thr = thr | (CFG_DATA_W'($urandom_range(0, 511)) << THR_W);
      sil = CFG_DATA_W'($urandom_range(0, 3)) | (CFG_DATA_W'($urandom_range(0, 16383)) << SIL_W);
      mx  = CFG_DATA_W'($urandom_range(1, 10)) | (CFG_DATA_W'($urandom_range(0, 255)) << MAX_W);
      mn  = CFG_DATA_W'($urandom_range(1, 8) * CHUNK_SAMPLES - $urandom_range(0, 1));
      set_config(thr, sil, mx, mn);
      for (int c = 0; c < PHASE_CHUNKS; c++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) loud_chunk();
        else if (pick < 70) quiet_chunk();
        else if (pick < 85) exact_chunk(predictor.level_threshold + $urandom_range(0, 1));
        else if (pick < 95) send_chunk(0, 0, 1'b1);
        else exact_chunk(32768);
      end
    end

    wait_drain();
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
